### hw/rtl/crr_pkg.sv
// ----------------------------------------------------------------------------
// crr_pkg
// shared widths, types and state codes for the canonical combining reorder
// ----------------------------------------------------------------------------
package crr_pkg;

  localparam int MAX_RUN = 32;
  localparam int CP_W    = 21;
  localparam int CLS_W   = 8;
  localparam int DATA_W  = 32;
  localparam int USER_W  = 2;

  typedef struct packed {
    logic             valid;
    logic [CP_W-1:0]  cp;
    logic [CLS_W-1:0] cls;
  } cell_ent_t;

  typedef struct packed {
    logic             insert;
    logic             pop;
    logic [CP_W-1:0]  cp;
    logic [CLS_W-1:0] cls;
  } cell_cmd_t;

  typedef struct packed {
    cell_ent_t head;
    logic      next_valid;
    logic      full;
  } chain_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_STARTER,
    ST_INSERT
  } state_t;

endpackage

### hw/rtl/crr_cell.sv
// ----------------------------------------------------------------------------
// crr_cell
// one slot of the sorted run: takes its left neighbour on insert, the new
// item where it belongs, and its right neighbour on pop
// ----------------------------------------------------------------------------
module crr_cell
  import crr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_cmd_t cmd,
  input  cell_ent_t left,
  input  logic      left_shift,
  input  cell_ent_t right,
  output cell_ent_t ent,
  output logic      shift
);

  cell_ent_t ent_next;

  assign shift = ent.valid && (ent.cls > cmd.cls);

  always_comb begin
    ent_next = ent;
    if (cmd.pop) begin
      ent_next = right;
    end else if (cmd.insert) begin
      if (left_shift) begin
        ent_next = left;
      end else if ((!ent.valid || shift) && left.valid) begin
        ent_next.valid = 1'b1;
        ent_next.cp    = cmd.cp;
        ent_next.cls   = cmd.cls;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else begin
      ent.valid <= ent_next.valid;
    end
    ent.cp  <= ent_next.cp;
    ent.cls <= ent_next.cls;
  end

endmodule

### hw/rtl/crr_chain.sv
// ----------------------------------------------------------------------------
// crr_chain
// row of cells holding the run in ascending class order, head at cell zero
// ----------------------------------------------------------------------------
module crr_chain
  import crr_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  cell_cmd_t     cmd,
  output chain_status_t status
);

  cell_ent_t ents   [MAX_RUN];
  logic      shifts [MAX_RUN];

  for (genvar i = 0; i < MAX_RUN; i++) begin : g_cell
    cell_ent_t left;
    logic      left_shift;
    cell_ent_t right;

    if (i == 0) begin : g_first
      assign left       = '{valid: 1'b1, cp: '0, cls: '0};
      assign left_shift = 1'b0;
    end else begin : g_mid
      assign left       = ents[i-1];
      assign left_shift = shifts[i-1];
    end

    if (i == MAX_RUN - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = ents[i+1];
    end

    crr_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .left       (left),
      .left_shift (left_shift),
      .right      (right),
      .ent        (ents[i]),
      .shift      (shifts[i])
    );
  end

  assign status.head       = ents[0];
  assign status.next_valid = ents[1].valid;
  assign status.full       = ents[MAX_RUN-1].valid;

endmodule

### hw/rtl/canonical_combining_reorder.sv
// ----------------------------------------------------------------------------
// canonical_combining_reorder
// stable sort of non-starter runs by combining class, flushed at each
// starter, at end of string and when the run buffer is full
// ----------------------------------------------------------------------------
// channel | dir | tdata                                | tlast        | tuser
// s_      | in  | [20:0] code_point, [28:21] comb_class | end_of_string | -
// m_      | out | [20:0] out_code_point, [28:21] out_class | last_of_run | [0] string_done,
//         |     |                                      |              | [1] run_overflow
//
// a non-starter that does not end the string and finds room in the buffer is
// inserted in the cycle it is taken, so such items flow at one per cycle
// any other item is taken, then each buffered item leaves the head cell in
// turn, one per cycle while the result register can load; a starter is then
// emitted, and an item that hit a full buffer is inserted after the flush
// the input is held off while a flush or a starter is being emitted or a held
// item is inserted; reset empties the run; the result register drains
// independently of input
// ----------------------------------------------------------------------------
module canonical_combining_reorder
  import crr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,   // code_point, comb_class
  input  logic              s_tlast,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,   // out_code_point, out_class
  output logic              m_tlast,
  output logic [USER_W-1:0] m_tuser    // string_done, run_overflow
);

  state_t        state, state_next;
  cell_cmd_t     cmd;
  chain_status_t status;

  logic [CP_W-1:0]  h_cp, h_cp_next;
  logic [CLS_W-1:0] h_cls, h_cls_next;
  logic             h_eos, h_eos_next;
  logic             f_ovf, f_ovf_next;
  logic             f_last, f_last_next;
  logic             f_done, f_done_next;

  logic             o_valid, o_valid_next;
  logic [CP_W-1:0]  o_cp, o_cp_next;
  logic [CLS_W-1:0] o_cls, o_cls_next;
  logic             o_last, o_last_next;
  logic             o_done, o_done_next;
  logic             o_ovf, o_ovf_next;

  logic             can_load;
  logic [CP_W-1:0]  in_cp;
  logic [CLS_W-1:0] in_cls;

  assign in_cp    = s_tdata[CP_W-1:0];
  assign in_cls   = s_tdata[CP_W+CLS_W-1:CP_W];
  assign can_load = !o_valid || m_tready;

  crr_chain u_chain (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .status (status)
  );

  always_comb begin
    state_next   = state;
    s_tready     = 1'b0;
    cmd          = '0;
    h_cp_next    = h_cp;
    h_cls_next   = h_cls;
    h_eos_next   = h_eos;
    f_ovf_next   = f_ovf;
    f_last_next  = f_last;
    f_done_next  = f_done;
    o_valid_next = o_valid && !m_tready;
    o_cp_next    = o_cp;
    o_cls_next   = o_cls;
    o_last_next  = o_last;
    o_done_next  = o_done;
    o_ovf_next   = o_ovf;

    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          h_cp_next  = in_cp;
          h_cls_next = in_cls;
          h_eos_next = s_tlast;
          if (in_cls == '0) begin
            f_ovf_next  = 1'b0;
            f_last_next = 1'b0;
            f_done_next = 1'b0;
            state_next  = status.head.valid ? ST_FLUSH : ST_STARTER;
          end else if (status.full) begin
            f_ovf_next  = 1'b1;
            f_last_next = !s_tlast;
            f_done_next = 1'b0;
            state_next  = ST_FLUSH;
          end else begin
            cmd.insert = 1'b1;
            cmd.cp     = in_cp;
            cmd.cls    = in_cls;
            if (s_tlast) begin
              f_ovf_next  = 1'b0;
              f_last_next = 1'b1;
              f_done_next = 1'b1;
              state_next  = ST_FLUSH;
            end
          end
        end
      end
      ST_FLUSH: begin
        if (can_load) begin
          cmd.pop      = 1'b1;
          o_valid_next = 1'b1;
          o_cp_next    = status.head.cp;
          o_cls_next   = status.head.cls;
          o_last_next  = f_last && !status.next_valid;
          o_done_next  = f_done && !status.next_valid;
          o_ovf_next   = f_ovf;
          if (!status.next_valid) begin
            if (h_cls == '0) begin
              state_next = ST_STARTER;
            end else if (f_ovf) begin
              state_next = ST_INSERT;
            end else begin
              state_next = ST_IDLE;
            end
          end
        end
      end
      ST_STARTER: begin
        if (can_load) begin
          o_valid_next = 1'b1;
          o_cp_next    = h_cp;
          o_cls_next   = h_cls;
          o_last_next  = 1'b1;
          o_done_next  = h_eos;
          o_ovf_next   = 1'b0;
          state_next   = ST_IDLE;
        end
      end
      ST_INSERT: begin
        cmd.insert = 1'b1;
        cmd.cp     = h_cp;
        cmd.cls    = h_cls;
        if (h_eos) begin
          f_ovf_next  = 1'b0;
          f_last_next = 1'b1;
          f_done_next = 1'b1;
          state_next  = ST_FLUSH;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      o_valid <= 1'b0;
    end else begin
      state   <= state_next;
      o_valid <= o_valid_next;
    end
    h_cp   <= h_cp_next;
    h_cls  <= h_cls_next;
    h_eos  <= h_eos_next;
    f_ovf  <= f_ovf_next;
    f_last <= f_last_next;
    f_done <= f_done_next;
    o_cp   <= o_cp_next;
    o_cls  <= o_cls_next;
    o_last <= o_last_next;
    o_done <= o_done_next;
    o_ovf  <= o_ovf_next;
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {{(DATA_W-CP_W-CLS_W){1'b0}}, o_cls, o_cp};
  assign m_tlast  = o_last;
  assign m_tuser  = {o_ovf, o_done};

  // end of string only ever on the closing item of an input
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tlast)
    else $error("string_done without last_of_run");

  // the run never grows past the last cell
  a_no_insert_full: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |-> !status.full)
    else $error("insert into a full run");

  // a flush always has something at the head
  a_flush_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_FLUSH |-> status.head.valid)
    else $error("flush with an empty run");

  // an overflowed run never closes the string
  a_ovf_not_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> !m_tuser[0])
    else $error("overflow item marked as end of string");

endmodule
